FILE: rtl/core/vefc_pkg.sv
// Package for the voxel exposed-face culler: widths, defaults and the query step codes.
`timescale 1ns / 1ps

package vefc_pkg;

  localparam int GRID_SIZE_DEF = 32;

  localparam int COORD_W = 5;
  localparam int MASK_W  = 6;
  // neighbor coordinate width: holds 0..64 and the wrapped value of 0 - 1
  localparam int NBR_W   = 7;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // read order of a query; mask bit of a neighbor step is its code minus one
  typedef enum logic [2:0] {
    STEP_CENTER = 3'd0,
    STEP_PY     = 3'd1,
    STEP_NY     = 3'd2,
    STEP_PZ     = 3'd3,
    STEP_NZ     = 3'd4,
    STEP_NX     = 3'd5,
    STEP_PX     = 3'd6
  } step_t;

endpackage

FILE: rtl/core/voxel_exposed_face_culler.sv
// Top level of the voxel exposed-face culler: occupancy grid memory and request sequencer.
`timescale 1ns / 1ps

// channel  direction  ports
// in       input      in_valid in_ready in_req_type in_pos_x/y/z in_solid_in
// out      output     out_valid out_ready out_cell_x/y/z out_cell_solid out_face_mask
//
// Query: reads the center and then the six neighbors, one read per cycle of the
// single-port grid memory, then passes S_LAST and S_DONE. Write: S_WRITE then S_DONE.
// Query outside the grid: straight to S_DONE, with no reads.
// After reset the grid is swept to empty, with in_ready low.
// The next beat is accepted while a result waits; a stalled output holds the
// sequencer in its last state until the result register frees.

module voxel_exposed_face_culler #(
  parameter int GRID_SIZE = vefc_pkg::GRID_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [vefc_pkg::COORD_W-1:0] in_pos_x,
  input  logic [vefc_pkg::COORD_W-1:0] in_pos_y,
  input  logic [vefc_pkg::COORD_W-1:0] in_pos_z,
  input  logic                         in_solid_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [vefc_pkg::COORD_W-1:0] out_cell_x,
  output logic [vefc_pkg::COORD_W-1:0] out_cell_y,
  output logic [vefc_pkg::COORD_W-1:0] out_cell_z,
  output logic                         out_cell_solid,
  output logic [vefc_pkg::MASK_W-1:0]  out_face_mask
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int AW    = 3 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = vefc_pkg::NBR_W;
  localparam int XW    = NW - vefc_pkg::COORD_W;
  localparam logic [NW-1:0] GRID_N = NW'(GRID_SIZE);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_LAST  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [AW-1:0]                  clr_cnt_r;
  vefc_pkg::step_t                step_r, pstep_r;
  logic                           pend_r, pin_r;
  logic [vefc_pkg::COORD_W-1:0]   x_r, y_r, z_r;
  logic                           req_r, solid_r, inside_r, center_r;
  logic [vefc_pkg::MASK_W-1:0]    mask_r;
  logic                           out_valid_r;
  logic [vefc_pkg::COORD_W-1:0]   ox_r, oy_r, oz_r;
  logic                           osolid_r;
  logic [vefc_pkg::MASK_W-1:0]    omask_r;

  logic                           mem [DEPTH];
  logic                           rd_q;
  logic                           mem_we, mem_wdata;
  logic [AW-1:0]                  mem_addr;

  logic [NW-1:0]                  cx, cy, cz, nx, ny, nz;
  logic                           nbr_in, in_inside, out_free, accept;
  logic [2:0]                     bit_idx;

  assign cx = {{XW{1'b0}}, x_r};
  assign cy = {{XW{1'b0}}, y_r};
  assign cz = {{XW{1'b0}}, z_r};

  assign in_inside = ({{XW{1'b0}}, in_pos_x} < GRID_N) &&
                     ({{XW{1'b0}}, in_pos_y} < GRID_N) &&
                     ({{XW{1'b0}}, in_pos_z} < GRID_N);

  always_comb begin
    nx = cx;
    ny = cy;
    nz = cz;
    unique case (step_r)
      vefc_pkg::STEP_PY: ny = cy + NW'(1);
      vefc_pkg::STEP_NY: ny = cy - NW'(1);
      vefc_pkg::STEP_PZ: nz = cz + NW'(1);
      vefc_pkg::STEP_NZ: nz = cz - NW'(1);
      vefc_pkg::STEP_NX: nx = cx - NW'(1);
      vefc_pkg::STEP_PX: nx = cx + NW'(1);
      default: ;
    endcase
  end

  // below zero wraps high, so one compare covers both edges
  assign nbr_in = (nx < GRID_N) && (ny < GRID_N) && (nz < GRID_N);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = solid_r;
    mem_addr  = {nx[CW-1:0], ny[CW-1:0], nz[CW-1:0]};
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = 1'b0;
        mem_addr  = clr_cnt_r;
      end
      S_WRITE: mem_we = inside_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rd_q <= mem[mem_addr];
  end

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign bit_idx  = 3'(pstep_r) - 3'd1;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (&clr_cnt_r) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_req_type == vefc_pkg::REQ_WRITE) begin
            state_nxt = S_WRITE;
          end else if (in_inside) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_READ:  if (step_r == vefc_pkg::STEP_PX) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_DONE;
      S_WRITE: state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      step_r      <= vefc_pkg::STEP_CENTER;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == S_READ);
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (accept) begin
        step_r <= vefc_pkg::STEP_CENTER;
      end else if (state_r == S_READ) begin
        step_r <= vefc_pkg::step_t'(3'(step_r) + 3'd1);
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_pos_x;
      y_r      <= in_pos_y;
      z_r      <= in_pos_z;
      req_r    <= in_req_type;
      solid_r  <= in_solid_in;
      inside_r <= in_inside;
      center_r <= 1'b0;
      mask_r   <= '0;
    end
    if (state_r == S_READ) begin
      pstep_r <= step_r;
      pin_r   <= nbr_in;
    end
    if (pend_r) begin
      if (pstep_r == vefc_pkg::STEP_CENTER) begin
        center_r <= pin_r && rd_q;
      end else begin
        mask_r[bit_idx] <= !(pin_r && rd_q);
      end
    end
    if (state_r == S_DONE && out_free) begin
      ox_r <= x_r;
      oy_r <= y_r;
      oz_r <= z_r;
      if (req_r == vefc_pkg::REQ_WRITE) begin
        osolid_r <= inside_r && solid_r;
        omask_r  <= '0;
      end else begin
        osolid_r <= center_r;
        omask_r  <= center_r ? mask_r : '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_x     = ox_r;
  assign out_cell_y     = oy_r;
  assign out_cell_z     = oz_r;
  assign out_cell_solid = osolid_r;
  assign out_face_mask  = omask_r;

endmodule
